// ===== design/tcw_pkg.sv =====
// Shared types and constants for the text console writer.
package tcw_pkg;

  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 24;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0A;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h0F;

  // Cell word in the screen store: character in the high byte.
  localparam int CELL_W = 16;
  localparam int POS_OUT_W = 11;

  typedef enum logic [1:0] {
    OP_READ,
    OP_NEWLINE,
    OP_PUT
  } op_t;

  // Classified request as it waits in the queue.
  typedef struct packed {
    op_t        op;
    logic       in_range;
    logic [7:0] character;
    logic [7:0] color;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } item_t;

  typedef struct packed {
    logic [POS_OUT_W-1:0] cursor_position;
    logic                 scrolled;
    logic [7:0]           cell_char;
    logic [7:0]           cell_color;
  } res_t;

endpackage

// ===== design/tcw_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/tcw_queue.sv =====
// Short request queue between the front and back ends.
module tcw_queue import tcw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  empty,
  output logic  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));
  assign head  = entries[rd_ptr];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/tcw_front.sv =====
// Front end: takes input requests, classifies them and range-checks reads.
module tcw_front import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       command,
  input  logic [7:0] character,
  input  logic [7:0] color,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  input  logic       init_busy,
  input  logic       q_full,
  output logic       push,
  output item_t      push_item
);

  // No request taken while the store is being cleared after reset.
  assign in_stall = rst || init_busy || q_full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    push_item.character = character;
    push_item.color     = color;
    push_item.read_row  = read_row;
    push_item.read_col  = read_col;
    push_item.in_range  = (7'(read_row) < 7'(ROWS)) && (8'(read_col) < 8'(COLUMNS));
    if (command) begin
      push_item.op = OP_READ;
    end else if (character == NEWLINE_CODE) begin
      push_item.op = OP_NEWLINE;
    end else begin
      push_item.op = OP_PUT;
    end
  end

endmodule

// ===== design/tcw_back.sv =====
// Back end: cursor, row ring, store accesses, row clearing and results.
module tcw_back import tcw_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF,
  localparam int COL_W  = $clog2(COLUMNS),
  localparam int ROW_W  = $clog2(ROWS),
  localparam int ADDR_W = ROW_W + COL_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  item_t             q_item,
  output logic              q_pop,
  input  logic [7:0]        default_color,
  output logic              init_busy,
  input  logic              out_stall,
  output logic              out_valid,
  output res_t              out_res,
  output logic              ram_we,
  output logic [ADDR_W-1:0] ram_waddr,
  output logic [CELL_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [ADDR_W-1:0] ram_raddr,
  input  logic [CELL_W-1:0] ram_rdata
);

  localparam int POS_W = $clog2(ROWS * COLUMNS);

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_CLEAR
  } state_t;

  state_t           state;
  logic [ROW_W-1:0] cursor_row;
  logic [COL_W-1:0] cursor_col;
  logic [POS_W-1:0] lin;
  logic [ROW_W-1:0] top;
  logic [ROW_W-1:0] clr_row;
  logic [COL_W-1:0] clr_col;
  logic [7:0]       fill_color;

  logic             issue;
  logic             res_load;
  logic             nl;
  logic             scroll;
  logic [ROW_W-1:0] phys_cur;
  logic [ROW_W-1:0] phys_read;
  logic [ROW_W-1:0] top_next;
  logic [ROW_W-1:0] row_next;
  logic [COL_W-1:0] col_next;
  logic [POS_W-1:0] lin_next;
  logic             clr_col_last;
  logic             clr_row_last;
  logic [ROW_W+4:0] rrow_ext;
  logic [COL_W+6:0] rcol_ext;

  function automatic logic [ROW_W-1:0] ring_add(input logic [ROW_W-1:0] a,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ROW_W + 1)'(ROWS)) begin
      sum = sum - (ROW_W + 1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [POS_OUT_W-1:0] to_pos(input logic [POS_W-1:0] p);
    logic [POS_W+POS_OUT_W-1:0] ext;
    ext = (POS_W + POS_OUT_W)'(p);
    return ext[POS_OUT_W-1:0];
  endfunction

  assign init_busy    = (state == ST_INIT);
  assign clr_col_last = (clr_col == COL_W'(COLUMNS - 1));
  assign clr_row_last = (clr_row == ROW_W'(ROWS - 1));
  assign issue        = (state == ST_IDLE) && !q_empty && (!out_valid || !out_stall);
  assign q_pop        = issue;
  // A result is loaded by any issued request except an in-range read, which
  // loads in the next cycle, from ST_READ, with the store data.
  assign res_load     = (issue && ((q_item.op != OP_READ) || !q_item.in_range)) ||
                        (state == ST_READ);

  always_comb begin
    rrow_ext  = (ROW_W + 5)'(q_item.read_row);
    rcol_ext  = (COL_W + 7)'(q_item.read_col);
    phys_cur  = ring_add(cursor_row, top);
    phys_read = ring_add(rrow_ext[ROW_W-1:0], top);
    top_next  = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;

    // Newline, either explicit or from filling the last column.
    nl     = (q_item.op == OP_NEWLINE) ||
             (q_item.op == OP_PUT && cursor_col == COL_W'(COLUMNS - 1));
    scroll = issue && (q_item.op != OP_READ) && nl &&
             (cursor_row == ROW_W'(ROWS - 1));

    if (nl) begin
      col_next = '0;
      row_next = (cursor_row == ROW_W'(ROWS - 1)) ? cursor_row : cursor_row + 1'b1;
      lin_next = lin - POS_W'(cursor_col) +
                 ((cursor_row == ROW_W'(ROWS - 1)) ? '0 : POS_W'(COLUMNS));
    end else begin
      col_next = cursor_col + 1'b1;
      row_next = cursor_row;
      lin_next = lin + 1'b1;
    end

    ram_we    = 1'b0;
    ram_waddr = {clr_row, clr_col};
    ram_wdata = {SPACE_CODE, fill_color};
    case (state)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {SPACE_CODE, RESET_COLOR};
      end
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (issue && q_item.op == OP_PUT) begin
          ram_we    = 1'b1;
          ram_waddr = {phys_cur, cursor_col};
          ram_wdata = {q_item.character, q_item.color};
        end
      end
      default: ;
    endcase

    ram_re    = issue && (q_item.op == OP_READ) && q_item.in_range;
    ram_raddr = {phys_read, rcol_ext[COL_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      cursor_row <= '0;
      cursor_col <= '0;
      lin        <= '0;
      top        <= '0;
      clr_row    <= '0;
      clr_col    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_INIT: begin
          if (clr_col_last) begin
            clr_col <= '0;
            clr_row <= clr_row + 1'b1;
            if (clr_row_last) begin
              state <= ST_IDLE;
            end
          end else begin
            clr_col <= clr_col + 1'b1;
          end
        end
        ST_IDLE: begin
          if (issue) begin
            case (q_item.op)
              OP_READ: begin
                if (q_item.in_range) begin
                  state <= ST_READ;
                end else begin
                  out_res   <= '{cursor_position: to_pos(lin), scrolled: 1'b0,
                                 cell_char: 8'h00, cell_color: 8'h00};
                end
              end
              OP_NEWLINE, OP_PUT: begin
                cursor_row <= row_next;
                cursor_col <= col_next;
                lin        <= lin_next;
                out_res    <= '{cursor_position: to_pos(lin_next), scrolled: scroll,
                                cell_char: 8'h00, cell_color: 8'h00};
                if (scroll) begin
                  // Old top row becomes the new bottom row; clear it.
                  top        <= top_next;
                  clr_row    <= top;
                  clr_col    <= '0;
                  fill_color <= default_color;
                  state      <= ST_CLEAR;
                end
              end
              default: ;
            endcase
          end
        end
        ST_READ: begin
          out_res   <= '{cursor_position: to_pos(lin), scrolled: 1'b0,
                         cell_char: ram_rdata[15:8], cell_color: ram_rdata[7:0]};
          state     <= ST_IDLE;
        end
        ST_CLEAR: begin
          if (clr_col_last) begin
            state <= ST_IDLE;
          end else begin
            clr_col <= clr_col + 1'b1;
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  a_lin_matches_cursor: assert property (@(posedge clk) disable iff (rst)
    lin == POS_W'(cursor_row) * POS_W'(COLUMNS) + POS_W'(cursor_col))
    else $error("linear cursor out of step with row and column");

  a_clear_cursor_row: assert property (@(posedge clk) disable iff (rst)
    state == ST_CLEAR |-> clr_row == phys_cur)
    else $error("cleared row is not the cursor row");

  a_scroll_to_clear: assert property (@(posedge clk) disable iff (rst)
    scroll |=> state == ST_CLEAR && cursor_row == ROW_W'(ROWS - 1) && cursor_col == '0)
    else $error("scroll did not start row clearing at the bottom row");

  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid)
    else $error("read data would overwrite a pending result");

endmodule

// ===== design/text_console_writer_unit.sv =====
// Top level of the text console writer: config register, front, queue, back, store.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   in      | input     | in_valid / in_stall   | command, character, color, read_row, read_col
//   out     | output    | out_valid / out_stall | cursor_position, scrolled, cell_char, cell_color
//   cfg     | input     | cfg_valid / cfg_ready | cfg_data (default_color)
//
// A put, a newline or an off-screen read has its result registered as it leaves the queue head;
// an in-range read has it registered from the store data in ST_READ (registered store read).
// A scroll then clears one row while no request issues; row offsets rotate.
// After reset a clearing pass writes every screen cell with in_stall high; cfg writes are
// taken throughout. The queue lets the front take requests while the back end clears a row
// or waits on out_stall.
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS     = COLUMNS_DEF,
  parameter int ROWS        = ROWS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [7:0]  character,
  input  logic [7:0]  color,
  input  logic [4:0]  read_row,
  input  logic [6:0]  read_col,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] cursor_position,
  output logic        scrolled,
  output logic [7:0]  cell_char,
  output logic [7:0]  cell_color,
  // default color register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int ADDR_W = ROW_W + COL_W;
  // Store rows are padded to a power of two so an address is {row, column}.
  localparam int STORE_DEPTH = ROWS * (1 << COL_W);

  logic [7:0]        default_color;
  logic              init_busy;
  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  item_t             push_item;
  item_t             head;
  res_t              res;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [CELL_W-1:0] ram_rdata;

  // Config register is always writable; it only affects rows cleared later.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_color <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      default_color <= cfg_data;
    end
  end

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .character (character),
    .color     (color),
    .read_row  (read_row),
    .read_col  (read_col),
    .init_busy (init_busy),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  tcw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_item        (head),
    .q_pop         (pop),
    .default_color (default_color),
    .init_busy     (init_busy),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_res       (res),
    .ram_we        (ram_we),
    .ram_waddr     (ram_waddr),
    .ram_wdata     (ram_wdata),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cursor_position = res.cursor_position;
  assign scrolled        = res.scrolled;
  assign cell_char       = res.cell_char;
  assign cell_color      = res.cell_color;

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for text_console_writer_unit: shadow screen, random text stream, result checks.

typedef enum logic {
  CMD_PUT  = 1'b0,
  CMD_READ = 1'b1
} command_e;

// Shadow of the console: its own screen, cursor and fill color. Every accepted
// request is applied here and the result it should produce is queued.
class console_shadow;
  localparam int COLS  = tcw_pkg::COLUMNS_DEF;
  localparam int LINES = tcw_pkg::ROWS_DEF;
  localparam int CELLS = COLS * LINES;

  logic [7:0] char_store [CELLS];
  logic [7:0] color_store [CELLS];
  int row_now;
  int col_now;
  logic [7:0] fill_color;
  int failures;
  tcw_pkg::res_t expected_results [$];

  function new();
    int i;
    fill_color = tcw_pkg::RESET_COLOR;
    for (i = 0; i < CELLS; i++) begin
      char_store[i]  = tcw_pkg::SPACE_CODE;
      color_store[i] = tcw_pkg::RESET_COLOR;
    end
    row_now  = 0;
    col_now  = 0;
    failures = 0;
  endfunction

  // Cursor to the start of the next line; scrolls off the bottom. Returns 1 on scroll.
  function bit line_feed();
    int i;
    col_now = 0;
    row_now++;
    if (row_now < LINES) return 1'b0;
    row_now = LINES - 1;
    for (i = 0; i < CELLS - COLS; i++) begin
      char_store[i]  = char_store[i + COLS];
      color_store[i] = color_store[i + COLS];
    end
    for (i = CELLS - COLS; i < CELLS; i++) begin
      char_store[i]  = tcw_pkg::SPACE_CODE;
      color_store[i] = fill_color;
    end
    return 1'b1;
  endfunction

  function void note_request(command_e cmd, logic [7:0] ch, logic [7:0] attr,
                             logic [4:0] rrow, logic [6:0] rcol);
    tcw_pkg::res_t want;
    int idx;
    want = '0;
    if (cmd == CMD_READ) begin
      if (rrow < LINES && rcol < COLS) begin
        idx = rrow * COLS + rcol;
        want.cell_char  = char_store[idx];
        want.cell_color = color_store[idx];
      end
    end else if (ch == tcw_pkg::NEWLINE_CODE) begin
      want.scrolled = line_feed();
    end else begin
      idx = row_now * COLS + col_now;
      char_store[idx]  = ch;
      color_store[idx] = attr;
      col_now++;
      if (col_now >= COLS) want.scrolled = line_feed();
    end
    want.cursor_position = 11'(row_now * COLS + col_now);
    expected_results.push_back(want);
  endfunction

  function void compare(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t mismatch on %s: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [10:0] pos, logic scr, logic [7:0] ch, logic [7:0] attr);
    tcw_pkg::res_t want;
    if (expected_results.size() == 0) begin
      failures++;
      $display("%0t unexpected result: expected none, got position %0d", $time, pos);
      return;
    end
    want = expected_results.pop_front();
    compare("cursor_position", 16'(want.cursor_position), 16'(pos));
    compare("scrolled", 16'(want.scrolled), 16'(scr));
    compare("cell_char", 16'(want.cell_char), 16'(ch));
    compare("cell_color", 16'(want.cell_color), 16'(attr));
  endfunction
endclass

module tb_top;
  import tcw_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 400;
  // A scroll clears one row after its result may already be out; let that finish
  // before the fill color changes.
  localparam int SETTLE_CYCLES = 2 * COLUMNS_DEF + 16;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [7:0]  character = '0;
  logic [7:0]  color = '0;
  logic [4:0]  read_row = '0;
  logic [6:0]  read_col = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [10:0] cursor_position;
  logic        scrolled;
  logic [7:0]  cell_char;
  logic [7:0]  cell_color;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;

  console_shadow shadow;

  int cycle_count = 0;
  int burst_left = 0;
  // receiver side
  bit hold_off_req = 1'b0;
  int hold_left = 0;
  int stall_mode = 0;
  int mode_left = 0;

  text_console_writer_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .character(character), .color(color),
    .read_row(read_row), .read_col(read_col),
    .out_valid(out_valid), .out_stall(out_stall),
    .cursor_position(cursor_position), .scrolled(scrolled),
    .cell_char(cell_char), .cell_color(cell_color),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Watchdog: covers the post-reset clear, the long hold and every stall.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      shadow.check_result(cursor_position, scrolled, cell_char, cell_color);
  end

  // Receiver: stall pattern runs in modes of random length (open, light,
  // heavy, periodic). A hold-off request parks it with out_stall high so the block
  // backs up and stalls its input.
  always @(negedge clk) begin
    if (hold_off_req) begin
      hold_left = HOLD_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 96);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= (mode_left % 5 < 2);
      endcase
    end
  end

  // Offer one request; the sender runs in bursts with random gaps in between.
  task automatic offer(command_e cmd, logic [7:0] ch, logic [7:0] attr,
                       logic [4:0] rrow, logic [6:0] rcol);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid  <= 1'b1;
    command   <= cmd;
    character <= ch;
    color     <= attr;
    read_row  <= rrow;
    read_col  <= rcol;
    do @(posedge clk); while (in_stall);
    shadow.note_request(cmd, ch, attr, rrow, rcol);
  endtask

  // Read request; other fields carry noise since a read ignores them.
  task automatic read_cell(logic [4:0] rrow, logic [6:0] rcol);
    offer(CMD_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), rrow, rcol);
  endtask

  task automatic random_read();
    logic [4:0] rrow;
    logic [6:0] rcol;
    case ($urandom_range(0, 3))
      0, 1: rrow = 5'(shadow.row_now);            // the row being typed
      2: rrow = 5'($urandom_range(0, ROWS_DEF - 1));
      default: rrow = 5'($urandom_range(0, 31));  // may be off screen
    endcase
    rcol = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                       : 7'($urandom_range(0, COLUMNS_DEF - 1));
    read_cell(rrow, rcol);
  endtask

  task automatic random_put();
    logic [7:0] ch;
    ch = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(0, 255));
    offer(CMD_PUT, ch, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
          7'($urandom_range(0, 127)));
  endtask

  // Text as lines: mostly short, some long enough to wrap, most ended by a
  // newline, with reads mixed in. Enough lines go by to scroll many times.
  task automatic type_lines(int count);
    int done;
    int len;
    int k;
    done = 0;
    while (done < count) begin
      len = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 40) : $urandom_range(60, 170);
      for (k = 0; k < len && done < count; k++) begin
        if ($urandom_range(0, 9) == 0) random_read();
        else random_put();
        done++;
      end
      if (done < count && $urandom_range(0, 4) != 0) begin
        offer(CMD_PUT, NEWLINE_CODE, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)),
              7'($urandom_range(0, 127)));
        done++;
      end
    end
  endtask

  // Drop valid, wait for every result, then let any row clear finish.
  task automatic settle();
    @(negedge clk) in_valid <= 1'b0;
    while (shadow.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_fill_color(logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    shadow.fill_color = value;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    shadow = new();
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // Directed: field extremes, each kind of request, off-screen reads,
    // and a read whose character field holds the newline code.
    offer(CMD_PUT, 8'h41, 8'h00, 5'd0, 7'd0);
    offer(CMD_PUT, 8'hFF, 8'hFF, 5'd31, 7'd127);
    offer(CMD_PUT, 8'h00, 8'h5A, 5'd0, 7'd0);
    offer(CMD_PUT, NEWLINE_CODE, 8'hFF, 5'd31, 7'd127);
    offer(CMD_READ, NEWLINE_CODE, 8'h00, 5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd0, 7'd2);
    read_cell(5'd0, 7'd3);
    read_cell(5'd1, 7'd0);
    read_cell(5'(ROWS_DEF - 1), 7'(COLUMNS_DEF - 1));
    read_cell(5'(ROWS_DEF), 7'd0);
    read_cell(5'd0, 7'(COLUMNS_DEF));
    read_cell(5'd31, 7'd127);
    read_cell(5'd31, 7'd0);
    read_cell(5'd0, 7'd127);
    offer(CMD_PUT, NEWLINE_CODE, 8'h00, 5'd0, 7'd0);
    offer(CMD_PUT, 8'h7E, 8'hC3, 5'd0, 7'd0);
    read_cell(5'd2, 7'd0);

    // Phase at the reset fill color, then one per setting.
    type_lines(PHASE_ITEMS);
    settle();
    write_fill_color(8'h00);
    type_lines(PHASE_ITEMS);
    settle();
    write_fill_color(8'hFF);
    hold_off_req = 1'b1;   // receiver backs off while the sender keeps going
    type_lines(PHASE_ITEMS);
    settle();
    write_fill_color(8'($urandom_range(1, 254)));
    type_lines(PHASE_ITEMS);
    settle();
    write_fill_color(8'hA5);
    type_lines(PHASE_ITEMS);
    settle();

    if (shadow.failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
